[sv/rau_pkg.sv]
// Package with shared opcodes, status codes and transaction types for the rational unit.
package rau_pkg;

  localparam int WordBits = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_LT  = 4'd4,
    OP_LE  = 4'd5,
    OP_EQ  = 4'd6,
    OP_NE  = 4'd7,
    OP_GE  = 4'd8,
    OP_GT  = 4'd9
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIVZERO  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               cmp_true;
    logic [1:0]         status;
  } rau_out_t;

endpackage

[sv/rational_arithmetic_unit_core.sv]
// Rational arithmetic unit: a sequencer around one shared 64-bit restoring divider.
//
// A transaction is taken when start is high and busy is low; busy then stays high until
// out_valid pulses for one cycle with the result, which the receiver must take at once.
// An unused opcode or a zero operand error goes from decode straight to the done state.
// Other transactions take longer; their time is set by the serial divider (one quotient
// bit per cycle) and the number of division steps of the two Euclid gcd loops, plus up
// to four fixed divisions and a few multiplies.
module rational_arithmetic_unit_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rau_pkg::rau_in_t  in_data,
  output logic              out_valid,
  output rau_pkg::rau_out_t out_data
);
  import rau_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_MULDEN, S_G1, S_G1DIV, S_LCM1, S_LCM1W, S_LCM2, S_LCM2W,
    S_XY, S_SUM, S_CMP, S_FIN, S_G2, S_G2DIV, S_RED1, S_RED1W, S_RED2, S_RED2W,
    S_CHECK, S_DONE
  } state_t;

  state_t             state_r;
  logic [3:0]         kind_r;
  logic signed [31:0] an_r, bn_r;
  logic [30:0]        ad_r, bd_r;
  logic [63:0]        ga_r, gb_r;
  logic [63:0]        mag_r, den_r;
  logic               neg_r;
  logic [63:0]        lcm_r, ma_r;
  logic signed [63:0] x_r, y_r;
  logic [63:0]        dq_r, dr_r, dd_r;
  logic [6:0]         dcnt_r;
  logic               out_valid_r;
  rau_out_t           out_r;

  logic [64:0] rtrial;
  logic [63:0] mag_a, mag_b;
  logic signed [64:0] sum;
  logic [63:0] lim;
  logic [63:0] smag;

  assign lim   = 64'd1 << (WordBits - 1);
  assign mag_a = an_r[31] ? 64'(-65'(an_r)) : 64'(an_r);
  assign mag_b = bn_r[31] ? 64'(-65'(bn_r)) : 64'(bn_r);
  assign rtrial = {dr_r, dq_r[63]} - {1'b0, dd_r};
  assign sum = (kind_r == OP_ADD) ? 65'(x_r) + 65'(y_r) : 65'(x_r) - 65'(y_r);
  assign smag = sum[64] ? 64'(-sum) : 64'(sum);

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      state_r     <= S_IDLE;
    end else begin
      out_valid_r <= (state_r == S_DONE);
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            kind_r  <= in_data.kind;
            an_r    <= in_data.a_num;
            bn_r    <= in_data.b_num;
            ad_r    <= in_data.a_den;
            bd_r    <= in_data.b_den;
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          out_r.res_num  <= '0;
          out_r.res_den  <= 31'd1;
          out_r.cmp_true <= 1'b0;
          if (kind_r > OP_GT) begin
            out_r.status <= ST_OK;
            state_r <= S_DONE;
          end else if (ad_r == '0 || bd_r == '0 || (kind_r == OP_DIV && bn_r == '0)) begin
            out_r.status <= ST_DIVZERO;
            state_r <= S_DONE;
          end else if (kind_r == OP_MUL || kind_r == OP_DIV) begin
            out_r.status <= ST_OK;
            neg_r <= an_r[31] ^ bn_r[31];
            if (kind_r == OP_MUL) begin
              mag_r <= 64'(mag_a[31:0]) * 64'(mag_b[31:0]);
              ga_r  <= 64'(ad_r);
              gb_r  <= 64'(bd_r);
            end else begin
              mag_r <= 64'(mag_a[31:0]) * 64'(bd_r);
              ga_r  <= 64'(ad_r);
              gb_r  <= mag_b;
            end
            state_r <= S_MULDEN;
          end else begin
            out_r.status <= ST_OK;
            ga_r <= 64'(ad_r);
            gb_r <= 64'(bd_r);
            state_r <= S_G1;
          end
        end
        S_MULDEN: begin
          den_r   <= 64'(ga_r[31:0]) * 64'(gb_r[31:0]);
          state_r <= S_FIN;
        end
        S_G1: begin
          if (gb_r == '0) begin
            dq_r <= 64'(ad_r); dd_r <= ga_r; dr_r <= '0; dcnt_r <= '0;
            state_r <= S_LCM1W;
          end else begin
            dq_r <= ga_r; dd_r <= gb_r; dr_r <= '0; dcnt_r <= '0;
            state_r <= S_G1DIV;
          end
        end
        S_LCM1W, S_LCM2W, S_G1DIV, S_G2DIV, S_RED1W, S_RED2W: begin
          if (rtrial[64]) begin
            dr_r <= {dr_r[62:0], dq_r[63]};
            dq_r <= {dq_r[62:0], 1'b0};
          end else begin
            dr_r <= rtrial[63:0];
            dq_r <= {dq_r[62:0], 1'b1};
          end
          dcnt_r <= dcnt_r + 7'd1;
          if (dcnt_r == 7'd63) begin
            unique case (state_r)
              S_G1DIV: state_r <= S_LCM1;
              S_G2DIV: state_r <= S_RED1;
              S_LCM1W: state_r <= S_LCM2;
              S_LCM2W: state_r <= S_XY;
              S_RED1W: state_r <= S_RED2;
              default: state_r <= S_CHECK;
            endcase
          end
        end
        S_LCM1: begin
          ga_r    <= gb_r;
          gb_r    <= dr_r;
          state_r <= S_G1;
        end
        S_LCM2: begin
          lcm_r   <= 64'(dq_r[30:0]) * 64'(bd_r);
          ma_r    <= dq_r;
          dq_r    <= 64'(bd_r); dd_r <= ga_r; dr_r <= '0; dcnt_r <= '0;
          state_r <= S_LCM2W;
        end
        S_XY: begin
          x_r     <= $signed(64'(an_r)) * $signed(64'(dq_r[30:0]));
          y_r     <= $signed(64'(bn_r)) * $signed(64'(ma_r[30:0]));
          state_r <= (kind_r <= OP_SUB) ? S_SUM : S_CMP;
        end
        S_SUM: begin
          neg_r   <= sum[64];
          mag_r   <= smag;
          den_r   <= lcm_r;
          state_r <= S_FIN;
        end
        S_CMP: begin
          case (kind_r)
            OP_LT:   out_r.cmp_true <= x_r <  y_r;
            OP_LE:   out_r.cmp_true <= x_r <= y_r;
            OP_EQ:   out_r.cmp_true <= x_r == y_r;
            OP_NE:   out_r.cmp_true <= x_r != y_r;
            OP_GE:   out_r.cmp_true <= x_r >= y_r;
            default: out_r.cmp_true <= x_r >  y_r;
          endcase
          state_r <= S_DONE;
        end
        S_FIN: begin
          if (mag_r == '0) begin
            state_r <= S_DONE;
          end else begin
            ga_r <= mag_r; gb_r <= den_r;
            state_r <= S_G2;
          end
        end
        S_G2: begin
          if (gb_r == '0) begin
            dq_r <= mag_r; dd_r <= ga_r; dr_r <= '0; dcnt_r <= '0;
            state_r <= S_RED1W;
          end else begin
            dq_r <= ga_r; dd_r <= gb_r; dr_r <= '0; dcnt_r <= '0;
            state_r <= S_G2DIV;
          end
        end
        S_RED1: begin
          ga_r    <= gb_r;
          gb_r    <= dr_r;
          state_r <= S_G2;
        end
        S_RED2: begin
          mag_r   <= dq_r;
          dq_r    <= den_r; dd_r <= ga_r; dr_r <= '0; dcnt_r <= '0;
          state_r <= S_RED2W;
        end
        S_CHECK: begin
          if (dq_r > lim - 64'd1 || (neg_r ? mag_r > lim : mag_r > lim - 64'd1)) begin
            out_r.status <= ST_OVERFLOW;
          end else begin
            out_r.res_num <= neg_r ? 32'(-mag_r) : mag_r[31:0];
            out_r.res_den <= dq_r[30:0];
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
